FILE: hw/rtl/shkt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shkt_pkg;

    localparam int KEY_BITS_MAX  = 64;
    localparam int VALUE_BITS_MAX = 64;
    localparam int SLOT_BITS_MAX = 16;
    localparam int COUNT_BITS    = 9;
    localparam int CFG_BITS      = 9;

    localparam logic [31:0] HASH_SEED  = 32'd5381;
    localparam int          HASH_SHIFT = 5;

    // remainder bits retired per cycle in the modulo unit
    localparam int MOD_RADIX_BITS = 4;
    localparam int MOD_STEPS      = 32 / MOD_RADIX_BITS;
    localparam int STEP_BITS      = $clog2(MOD_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_GET,
        OP_DELETE,
        OP_CLEAR
    } opcode_t;

    typedef enum logic [0:0] {
        ST_DONE,
        ST_FULL
    } status_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key_bytes;
        logic [3:0]  key_length;
        logic [31:0] value_in;
    } req_t;

    typedef struct packed {
        logic                  found;
        logic [31:0]           value_out;
        logic                  status;
        logic [COUNT_BITS-1:0] entry_count;
    } rsp_t;

    // command handed from the hashing side to the table side
    typedef struct packed {
        opcode_t                  op;
        logic [KEY_BITS_MAX-1:0]  key;
        logic [3:0]               len;
        logic [VALUE_BITS_MAX-1:0] value;
        logic [SLOT_BITS_MAX-1:0] start;
    } cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_MOD,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_ISSUE,
        B_CHECK,
        B_CLEAR,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/shkt_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface shkt_req_if;
    import shkt_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/shkt_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface shkt_rsp_if;
    import shkt_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/shkt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module shkt_front #(
    parameter int KEY_CHARS = 8,
    parameter int SIZE_BITS = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              init_done,
    input  logic [SIZE_BITS-1:0] size,
    shkt_req_if.sink          req,
    output logic              push_valid,
    input  logic              push_ready,
    output shkt_pkg::cmd_t    push_cmd
);
    import shkt_pkg::*;

    front_state_t st_reg, st_next;
    opcode_t      op_reg, op_next;
    logic [63:0]  key_reg, key_next;
    logic [3:0]   len_reg, len_next;
    logic [63:0]  val_reg, val_next;
    logic [31:0]  hash_reg, hash_next;
    logic [63:0]  shift_reg, shift_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [31:0]  div_reg, div_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next;
    logic [STEP_BITS-1:0] step_reg, step_next;

    logic        accept;
    logic [3:0]  lim;
    logic [63:0] canon_key;
    logic [3:0]  canon_len;
    logic        alive;
    logic [SIZE_BITS:0]   r_wide;
    logic [SIZE_BITS-1:0] r_cur;
    logic [31:0] d_cur;
    logic [31:0] start_ext;

    assign accept = req.valid && req.ready;

    // key ends at the first zero byte within the requested length
    always_comb
    begin
        lim = (req.data.key_length > 4'(KEY_CHARS)) ? 4'(KEY_CHARS) : req.data.key_length;
        canon_key = '0;
        canon_len = '0;
        alive = 1'b1;
        for (int b = 0; b < 8; b++)
        begin
            alive = alive && (4'(b) < lim) && (req.data.key_bytes[8*b +: 8] != 8'd0);
            if (alive)
            begin
                canon_key[8*b +: 8] = req.data.key_bytes[8*b +: 8];
                canon_len = canon_len + 4'd1;
            end
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    st_next = (req.data.opcode == OP_CLEAR) ? F_PUSH : F_HASH;
                end
            end
            F_HASH:
            begin
                if (cnt_reg == len_reg)
                begin
                    st_next = F_MOD;
                end
            end
            F_MOD:
            begin
                if (step_reg == STEP_BITS'(MOD_STEPS - 1))
                begin
                    st_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    st_next = F_IDLE;
                end
            end
            default: st_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready  = (st_reg == F_IDLE) && init_done;
        push_valid = (st_reg == F_PUSH);
        start_ext  = '0;
        start_ext[SIZE_BITS-1:0] = rem_reg;
        push_cmd.op    = op_reg;
        push_cmd.key   = key_reg;
        push_cmd.len   = len_reg;
        push_cmd.value = val_reg;
        push_cmd.start = start_ext[SLOT_BITS_MAX-1:0];
    end

    always_comb
    begin
        op_next    = op_reg;
        key_next   = key_reg;
        len_next   = len_reg;
        val_next   = val_reg;
        hash_next  = hash_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        r_wide     = '0;
        r_cur      = rem_reg;
        d_cur      = div_reg;
        case (st_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    op_next    = opcode_t'(req.data.opcode);
                    key_next   = canon_key;
                    len_next   = canon_len;
                    val_next   = {32'd0, req.data.value_in};
                    hash_next  = HASH_SEED;
                    shift_next = canon_key;
                    cnt_next   = '0;
                    rem_next   = '0;
                end
            end
            F_HASH:
            begin
                if (cnt_reg != len_reg)
                begin
                    hash_next  = (hash_reg << HASH_SHIFT) + hash_reg + {24'd0, shift_reg[7:0]};
                    shift_next = shift_reg >> 8;
                    cnt_next   = cnt_reg + 4'd1;
                end
                else
                begin
                    div_next  = hash_reg;
                    rem_next  = '0;
                    step_next = '0;
                end
            end
            F_MOD:
            begin
                // restoring remainder, msb first
                for (int k = 0; k < MOD_RADIX_BITS; k++)
                begin
                    r_wide = {r_cur, d_cur[31]};
                    d_cur  = d_cur << 1;
                    if (r_wide >= {1'b0, size})
                    begin
                        r_wide = r_wide - {1'b0, size};
                    end
                    r_cur = r_wide[SIZE_BITS-1:0];
                end
                rem_next  = r_cur;
                div_next  = d_cur;
                step_next = step_reg + STEP_BITS'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= F_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        len_reg   <= len_next;
        val_reg   <= val_next;
        hash_reg  <= hash_next;
        shift_reg <= shift_next;
        cnt_reg   <= cnt_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/shkt_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module shkt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  shkt_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output shkt_pkg::cmd_t pop_cmd
);
    import shkt_pkg::*;

    cmd_t entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_reg, wr_next;
    logic [QPTR_BITS-1:0] rd_reg, rd_next;
    logic [QPTR_BITS:0]   fill_reg, fill_next;
    logic do_push, do_pop;

    assign push_ready = (fill_reg != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_next   = do_push ? wr_reg + QPTR_BITS'(1) : wr_reg;
        rd_next   = do_pop ? rd_reg + QPTR_BITS'(1) : rd_reg;
        fill_next = fill_reg + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/shkt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module shkt_back #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_CHARS   = 8,
    parameter int VALUE_BITS  = 32,
    parameter int SLOT_BITS   = 8,
    parameter int SIZE_BITS   = 9
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [SIZE_BITS-1:0] size,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  shkt_pkg::cmd_t pop_cmd,
    output logic           init_done,
    shkt_rsp_if.source     rsp
);
    import shkt_pkg::*;

    localparam int KW = 8 * KEY_CHARS;

    logic            valid_mem [TABLE_DEPTH];
    logic [3:0]      len_mem   [TABLE_DEPTH];
    logic [KW-1:0]   key_mem   [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];

    back_state_t st_reg, st_next;
    cmd_t        cmd_reg, cmd_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic [SIZE_BITS-1:0] n_reg, n_next;
    logic [SLOT_BITS-1:0] clr_reg, clr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic        out_valid_reg, out_valid_next;
    rsp_t        out_reg, out_next;

    logic        rv_reg;
    logic [3:0]  rlen_reg;
    logic [KW-1:0] rkey_reg;
    logic [VALUE_BITS-1:0] rval_reg;

    logic        out_free, rd_en, load, match, empty, last, decide, hit, slot_ok;
    logic        wv_en, wv_data, wkv_en;
    logic [SLOT_BITS-1:0] w_addr;
    logic        clr_last;
    logic [31:0] idx_ext, n_ext, size_ext;
    logic [63:0] prev_ext;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;
    assign init_done = (st_reg != B_INIT);

    always_comb
    begin
        size_ext = '0;
        size_ext[SIZE_BITS-1:0] = size;
        idx_ext = '0;
        idx_ext[SLOT_BITS-1:0] = idx_reg;
        n_ext = '0;
        n_ext[SIZE_BITS-1:0] = n_reg;
        match  = rv_reg && (rlen_reg == cmd_reg.len) && (rkey_reg == cmd_reg.key[KW-1:0]);
        empty  = !rv_reg;
        last   = (n_ext + 32'd1 == size_ext);
        decide = empty || match || last;
        hit    = match;
        slot_ok = empty || match;
        clr_last = (clr_reg == SLOT_BITS'(TABLE_DEPTH - 1));
        prev_ext = '0;
        prev_ext[VALUE_BITS-1:0] = rval_reg;
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            B_INIT:
            begin
                if (clr_last)
                begin
                    st_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    st_next = (pop_cmd.op == OP_CLEAR) ? B_CLEAR : B_ISSUE;
                end
            end
            B_ISSUE: st_next = B_CHECK;
            B_CHECK:
            begin
                if (!decide)
                begin
                    st_next = B_ISSUE;
                end
                else if (out_free)
                begin
                    st_next = B_IDLE;
                end
            end
            B_CLEAR:
            begin
                if (clr_last)
                begin
                    st_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    st_next = B_IDLE;
                end
            end
            default: st_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop_ready      = (st_reg == B_IDLE);
        rd_en          = (st_reg == B_ISSUE);
        load           = 1'b0;
        wv_en          = 1'b0;
        wv_data        = 1'b0;
        wkv_en         = 1'b0;
        w_addr         = idx_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (st_reg)
            B_INIT, B_CLEAR:
            begin
                wv_en    = 1'b1;
                w_addr   = clr_reg;
                clr_next = clr_reg + SLOT_BITS'(1);
                if (clr_last)
                begin
                    count_next = '0;
                end
            end
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    cmd_next = pop_cmd;
                    idx_next = pop_cmd.start[SLOT_BITS-1:0];
                    n_next   = '0;
                    clr_next = '0;
                end
            end
            B_CHECK:
            begin
                if (!decide)
                begin
                    idx_next = (idx_ext + 32'd1 == size_ext) ? '0 : idx_reg + SLOT_BITS'(1);
                    n_next   = n_reg + SIZE_BITS'(1);
                end
                else if (out_free)
                begin
                    load = 1'b1;
                    out_next.found     = hit;
                    out_next.value_out = hit ? prev_ext[31:0] : 32'd0;
                    out_next.status    = ST_DONE;
                    if (cmd_reg.op == OP_INSERT)
                    begin
                        if (slot_ok)
                        begin
                            wv_en   = 1'b1;
                            wv_data = 1'b1;
                            wkv_en  = 1'b1;
                            if (!hit)
                            begin
                                count_next = count_reg + COUNT_BITS'(1);
                            end
                        end
                        else
                        begin
                            out_next.status = ST_FULL;
                        end
                    end
                    else if ((cmd_reg.op == OP_DELETE) && hit)
                    begin
                        wv_en      = 1'b1;
                        count_next = count_reg - COUNT_BITS'(1);
                    end
                    out_next.entry_count = count_next;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    out_next.found       = 1'b0;
                    out_next.value_out   = '0;
                    out_next.status      = ST_DONE;
                    out_next.entry_count = '0;
                end
            end
            default:
            begin
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_INIT;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        n_reg   <= n_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wv_en)
        begin
            valid_mem[w_addr] <= wv_data;
        end
        if (wkv_en)
        begin
            len_mem[w_addr] <= cmd_reg.len;
            key_mem[w_addr] <= cmd_reg.key[KW-1:0];
            val_mem[w_addr] <= cmd_reg.value[VALUE_BITS-1:0];
        end
        if (rd_en)
        begin
            rv_reg   <= valid_mem[idx_reg];
            rlen_reg <= len_mem[idx_reg];
            rkey_reg <= key_mem[idx_reg];
            rval_reg <= val_mem[idx_reg];
        end
    end

`ifndef SYNTHESIS
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == B_CHECK) |-> (n_reg < size))
        else $error("probe count beyond active size");

    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready && (pop_cmd.op == OP_CLEAR)) |=> (st_reg == B_CLEAR))
        else $error("clear did not start its sweep");

    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_next.status) |-> ((cmd_reg.op == OP_INSERT) && !wv_en
            && (count_next == count_reg)))
        else $error("rejected insert changed the table");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/string_key_hash_table.sv
// path: the byte-serial hash and the modulo unit in the front, the command queue, then an issue
//   and a check state per probed slot in the table back end, plus one output register stage
// the front takes a new request only once it has pushed the last command, after the byte-serial
//   hash and the 4-bit-per-cycle modulo unit; long probe chains slow the back end
// clear all sweeps all TABLE_DEPTH slots of the valid memory, one slot per cycle
// reset: asynchronous active low; table_size returns to 256, then a clearing pass over all
//   TABLE_DEPTH slots empties the valid memory while no request is taken
`timescale 1ns / 1ps
`default_nettype none

module string_key_hash_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_CHARS   = 8,
    parameter int VALUE_BITS  = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [8:0] cfg_wr_data,
    shkt_req_if.sink   req,
    shkt_rsp_if.source rsp
);
    import shkt_pkg::*;

    // slot index width and a size width that can also hold the depth itself
    localparam int SLOT_BITS = $clog2(TABLE_DEPTH);
    localparam int SIZE_BITS = (SLOT_BITS + 1 > CFG_BITS) ? SLOT_BITS + 1 : CFG_BITS;

    logic [CFG_BITS-1:0]  size_cfg_reg;
    logic [SIZE_BITS-1:0] size_eff;
    logic [31:0]          size_wide;

    logic init_done;
    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    // table_size register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= CFG_BITS'(256);
        end
        else if (cfg_wr_en)
        begin
            size_cfg_reg <= cfg_wr_data;
        end
    end

    // zero acts as one, anything above the depth acts as the depth
    always_comb
    begin
        size_wide = {23'd0, size_cfg_reg};
        if (size_wide == 32'd0)
        begin
            size_wide = 32'd1;
        end
        else if (size_wide > 32'(TABLE_DEPTH))
        begin
            size_wide = 32'(TABLE_DEPTH);
        end
        size_eff = size_wide[SIZE_BITS-1:0];
    end

    // front: key cleanup, djb2 hash and start slot
    shkt_front #(
        .KEY_CHARS (KEY_CHARS),
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .init_done  (init_done),
        .size       (size_eff),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // short command queue so hashing runs ahead of the probe walk
    shkt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // back: slot memory, linear probe walk and result register
    shkt_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_CHARS   (KEY_CHARS),
        .VALUE_BITS  (VALUE_BITS),
        .SLOT_BITS   (SLOT_BITS),
        .SIZE_BITS   (SIZE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .size      (size_eff),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .init_done (init_done),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
